@@ rtl/core/givm_pkg.sv @@
// Package for the grouped inverse-variance weighted mean block.
// Holds the controller state type, the command/status structs and field widths.
// Depends on nothing.
package givm_pkg;

   localparam int GROUP_COUNT_DEF = 64;
   localparam int LABEL_W = 6;
   localparam int DATA_W = 32;
   localparam int SUM_W = 64;
   localparam int DIV_STEPS = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WDIV,
      ST_MUL,
      ST_PROD,
      ST_RMW,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_MDIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // capture a new study
      logic wdiv_start;  // start the weight division
      logic mul;         // form effect * weight
      logic acc;         // accumulate into the group entry
      logic scan_start;  // reset the scan pointer
      logic scan_sel;    // address the sum RAM with the scan pointer
      logic scan_read;   // latch the entry under the scan pointer
      logic mdiv_start;  // start the mean division
      logic emit;        // load the output register
      logic scan_next;   // advance and clear the seen mark of the scanned entry
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic study_last;
      logic scan_seen;
      logic scan_end;
      logic any_after;
   } sts_type;

endpackage

@@ rtl/core/givm_datapath.sv @@
// Datapath: per-group sums in a RAM, shared restoring divider, multiplier,
// followed by the small generic RAM module that holds the sums.
// Depends on givm_pkg.
module givm_datapath
   import givm_pkg::*;
#(
   parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic [DATA_W-1:0]         between_variance,
   input  logic [LABEL_W-1:0]        in_label,
   input  logic signed [DATA_W-1:0]  in_effect,
   input  logic [DATA_W-1:0]         in_variance,
   input  logic                      in_last,
   output logic [LABEL_W-1:0]        out_label,
   output logic [DATA_W-1:0]         out_mean,
   output logic                      out_last
);
   localparam int IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int CNT_W = $clog2(DIV_STEPS + 1);
   localparam int ENT_W = 2 * SUM_W;

   logic [LABEL_W-1:0]          lab_ff;
   logic signed [DATA_W-1:0]    eff_ff;
   logic [DATA_W:0]             den_ff;
   logic                        last_ff;
   logic [DATA_W-1:0]           w_ff;
   logic signed [SUM_W-1:0]     prod_ff;

   logic [GROUP_COUNT-1:0]      seen_ff;

   logic [IDX_W:0]              ptr_ff;
   logic                        neg_ff;
   logic                        zero_ff;

   // Shared restoring divider, one quotient bit per cycle.
   logic [SUM_W-1:0]            dvd_ff, dvs_ff, quo_ff;
   logic [SUM_W:0]              rem_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic [SUM_W:0]              rem_sh, rem_sub;

   logic [IDX_W-1:0]            li, pi, rd_addr;
   logic                        lab_ok;
   logic                        ram_we;
   logic [ENT_W-1:0]            ram_wdata, ram_rdata;
   logic [SUM_W-1:0]            rd_wes, rd_ws;
   logic signed [SUM_W-1:0]     swes, nwes;
   logic [SUM_W-1:0]            sws, nws, mag;
   logic [SUM_W:0]              ws_sum;
   logic [DATA_W:0]             d_in;
   logic [GROUP_COUNT-1:0]      above;

   assign li = IDX_W'(lab_ff);
   assign pi = ptr_ff[IDX_W-1:0];
   assign lab_ok = int'(lab_ff) < GROUP_COUNT;
   assign d_in = {1'b0, in_variance} + {1'b0, between_variance};

   // A sum entry counts only while its seen mark is set, so the RAM needs no
   // clearing after reset or after a report.
   assign rd_addr   = cmd.scan_sel ? pi : li;
   assign ram_we    = cmd.acc && lab_ok;
   assign ram_wdata = {nwes, nws};

   givm_ram #(.WIDTH(ENT_W), .DEPTH(GROUP_COUNT), .ADDR_W(IDX_W)) u_sums (
      .clock,
      .wr_en   (ram_we),
      .wr_addr (li),
      .wr_data (ram_wdata),
      .rd_addr,
      .rd_data (ram_rdata)
   );

   assign rd_wes = ram_rdata[ENT_W-1:SUM_W];
   assign rd_ws  = ram_rdata[SUM_W-1:0];

   assign rem_sh  = {rem_ff[SUM_W-1:0], dvd_ff[SUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.wdiv_start || cmd.mdiv_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNT_W'(1));
      end
      if (cmd.wdiv_start) begin
         dvd_ff <= SUM_W'(64'h1_0000_0000);
         dvs_ff <= SUM_W'(den_ff);
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.mdiv_start) begin
         dvd_ff <= mag;
         dvs_ff <= rd_ws == '0 ? SUM_W'(1) : rd_ws;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         if (!rem_sub[SUM_W]) begin
            rem_ff <= rem_sub;
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   assign sts.div_done = !busy_ff;

   // Magnitude of the scanned weighted-effect sum.
   assign mag = rd_wes[SUM_W-1] ? SUM_W'(-rd_wes) : rd_wes;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lab_ff  <= in_label;
         eff_ff  <= in_effect;
         den_ff  <= d_in;
         last_ff <= in_last;
      end
      if (cmd.mul) begin
         if (den_ff <= (DATA_W+1)'(1))
            w_ff <= '1;
         else if (quo_ff[SUM_W-1:DATA_W] != '0)
            w_ff <= '1;
         else
            w_ff <= quo_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= eff_ff * $signed({1'b0, w_ff});
   end

   always_comb begin
      swes = seen_ff[li] ? $signed(rd_wes) : '0;
      sws  = seen_ff[li] ? rd_ws : '0;
      nwes = swes + prod_ff;
      if (!prod_ff[SUM_W-1] && !swes[SUM_W-1] && nwes[SUM_W-1])
         nwes = {1'b0, {(SUM_W-1){1'b1}}};
      else if (prod_ff[SUM_W-1] && swes[SUM_W-1] && !nwes[SUM_W-1])
         nwes = {1'b1, {(SUM_W-1){1'b0}}};
      ws_sum = {1'b0, sws} + {{(SUM_W-DATA_W+1){1'b0}}, w_ff};
      nws = ws_sum[SUM_W] ? '1 : ws_sum[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         if (ram_we)
            seen_ff[li] <= 1'b1;
         if (cmd.scan_next)
            seen_ff[pi] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ptr_ff <= '0;
      else if (cmd.scan_start) ptr_ff <= '0;
      else if (cmd.scan_next) ptr_ff <= ptr_ff + 1'b1;
      if (cmd.scan_read) begin
         neg_ff  <= rd_wes[SUM_W-1];
         zero_ff <= rd_ws == '0;
      end
   end

   // Entries above the scan pointer that are still marked seen.
   always_comb begin
      for (int i = 0; i < GROUP_COUNT; i++)
         above[i] = seen_ff[i] && ((IDX_W+1)'(i) > ptr_ff);
   end

   assign sts.study_last = last_ff;
   assign sts.scan_seen  = seen_ff[pi];
   assign sts.scan_end   = ptr_ff == (IDX_W+1)'(GROUP_COUNT - 1);
   assign sts.any_after  = |above;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_label <= LABEL_W'(ptr_ff);
         out_last  <= !(|above);
         if (zero_ff)
            out_mean <= '0;
         else if (!neg_ff)
            out_mean <= (quo_ff > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                        : quo_ff[DATA_W-1:0];
         else
            out_mean <= (quo_ff > SUM_W'(32'h8000_0000)) ? 32'h8000_0000
                        : DATA_W'(-quo_ff[DATA_W-1:0]);
      end
   end

endmodule

// Generic simple dual-port RAM with a registered read.
module givm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/core/givm_ctrl.sv @@
// Controller state machine: sequences a study through divide, multiply and
// accumulate, then scans the groups for the report. Depends on givm_pkg.
module givm_ctrl
   import givm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in   = state_ff;
      vld_in     = vld_ff && !rsp_tready;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            cmd.wdiv_start = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.div_done) begin
               cmd.mul  = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            // The product register picks up the new weight here.
            state_in = ST_RMW;
         end
         ST_RMW: begin
            cmd.acc  = 1'b1;
            state_in = sts.study_last ? ST_SCAN : ST_IDLE;
            cmd.scan_start = sts.study_last;
         end
         ST_SCAN: begin
            cmd.scan_sel = 1'b1;
            if (sts.scan_seen) begin
               state_in = ST_SCAN_WAIT;
            end else if (sts.scan_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SCAN_WAIT: begin
            // The RAM word addressed in the scan cycle is valid now.
            cmd.scan_read  = 1'b1;
            cmd.mdiv_start = 1'b1;
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (sts.div_done && !vld_in) begin
               cmd.emit = 1'b1;
               vld_in   = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.scan_next = 1'b1;
            state_in = (sts.scan_end || !sts.any_after) ? ST_IDLE : ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/core/grouped_inverse_variance_mean.sv @@
// Top level of the grouped inverse-variance weighted mean block.
// Depends on givm_pkg, givm_ctrl and givm_datapath.
//
// Studies enter on the req_ stream; one word carries a label, effect and
// variance, and tlast marks the last study of a set. For each study the block
// divides 2^32 by (variance + between_variance) to get a Q16.16 weight, then
// adds weight and effect*weight into the group's saturating 64-bit sums,
// which are kept in a small RAM.
// A study is accepted only after the last one has passed load, divider
// start, the shared 64-step restoring divider, product and read-modify-write.
// req_tready is high only while the block is idle.
// After the last study it walks the groups in ascending label order and sends
// one rsp_ word per group seen, with the weighted mean, then clears its mark.
// For each group seen the report passes scan, scan wait, mean division and
// emit; an unseen label is passed over in the scan state.
// The result sits in an output register; while rsp_tready is low the block
// finishes the next mean division and then waits with it, taking no study.
// csr_wr_en writes between_variance; write it only while idle.
// Reset clears the register, the seen marks, the controller and both streams.
module grouped_inverse_variance_mean
   import givm_pkg::*;
#(
   parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // group_label[5:0], effect_size[37:6],
                                   // sampling_variance[69:38], zero pad
   input  logic        req_tlast,  // last_study
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // group_label_res[5:0], weighted_mean[37:6],
                                   // zero pad
   output logic        rsp_tlast,  // last_group
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   cmd_type cmd;
   sts_type sts;
   logic [DATA_W-1:0]  bv_ff;
   logic [LABEL_W-1:0] out_label;
   logic [DATA_W-1:0]  out_mean;

   always_ff @(posedge clock) begin
      if (reset) bv_ff <= '0;
      else if (csr_wr_en) bv_ff <= csr_wr_data;
   end

   givm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   givm_datapath #(.GROUP_COUNT(GROUP_COUNT)) u_dp (
      .clock, .reset, .cmd, .sts,
      .between_variance (bv_ff),
      .in_label         (req_tdata[5:0]),
      .in_effect        (req_tdata[37:6]),
      .in_variance      (req_tdata[69:38]),
      .in_last          (req_tlast),
      .out_label        (out_label),
      .out_mean         (out_mean),
      .out_last         (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_mean, out_label};

endmodule

@@ rtl/core/givm_checker.sv @@
// Port-level checker for the grouped mean block, bound to the top level.
// Depends on nothing but the top-level ports.
module givm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("study accepted while busy");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:38] == 2'b00)
      else $error("rsp pad bits set");

   a_no_accept_in_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("study taken during report");
endmodule

bind grouped_inverse_variance_mean givm_checker u_givm_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);
